// ----- src/rate_monotonic_schedulability_test_top_assert.svh -----
// Assertion macros for the schedulability test top level.
// Included by rate_monotonic_schedulability_test_top.sv.
`ifndef RATE_MONOTONIC_SCHEDULABILITY_TEST_TOP_ASSERT_SVH
`define RATE_MONOTONIC_SCHEDULABILITY_TEST_TOP_ASSERT_SVH

// Implication checked on every edge outside reset.
`define RMS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define RMS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/rms_pkg.sv -----
// Package for the schedulability test: types, constants, bound table, divider width.
// No dependencies.
`timescale 1ns / 1ps
package rms_pkg;
    localparam int unsigned MaxTasksDefault = 63;
    localparam int unsigned IdxW = 6;
    localparam int unsigned CntW = 7;
    localparam int unsigned DataW = 32;
    localparam int unsigned QuoW = 48;
    localparam int unsigned SumW = 56;
    localparam int unsigned BndW = 17;

    typedef enum logic [3:0] {
        ST_LOAD, ST_INIT, ST_SORT_RD, ST_SORT_CMP, ST_SORT_WR, ST_TST_RD,
        ST_TST_LD, ST_TST_DIV, ST_TST_CHK, ST_OUT_RD, ST_OUT_EMIT
    } t_state;

    typedef struct packed {
        logic start;
        logic [DataW-1:0] num;
        logic [DataW-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic done;
        logic [QuoW-1:0] quo;
    } t_div_rsp;

    function automatic logic [BndW-1:0] bound_q16(input logic [IdxW-1:0] k);
        logic [BndW-1:0] b;
        case (k)
            6'd0: b = 17'd65536; 6'd1: b = 17'd54291; 6'd2: b = 17'd51102;
            6'd3: b = 17'd49599; 6'd4: b = 17'd48725; 6'd5: b = 17'd48154;
            6'd6: b = 17'd47751; 6'd7: b = 17'd47452; 6'd8: b = 17'd47221;
            6'd9: b = 17'd47037; 6'd10: b = 17'd46888; 6'd11: b = 17'd46763;
            6'd12: b = 17'd46658; 6'd13: b = 17'd46569; 6'd14: b = 17'd46492;
            6'd15: b = 17'd46424; 6'd16: b = 17'd46365; 6'd17: b = 17'd46312;
            6'd18: b = 17'd46264; 6'd19: b = 17'd46222; 6'd20: b = 17'd46184;
            6'd21: b = 17'd46149; 6'd22: b = 17'd46117; 6'd23: b = 17'd46088;
            6'd24: b = 17'd46061; 6'd25: b = 17'd46036; 6'd26: b = 17'd46014;
            6'd27: b = 17'd45993; 6'd28: b = 17'd45973; 6'd29: b = 17'd45954;
            6'd30: b = 17'd45937; 6'd31: b = 17'd45921; 6'd32: b = 17'd45906;
            6'd33: b = 17'd45892; 6'd34: b = 17'd45878; 6'd35: b = 17'd45866;
            6'd36: b = 17'd45854; 6'd37: b = 17'd45842; 6'd38: b = 17'd45832;
            6'd39: b = 17'd45821; 6'd40: b = 17'd45812; 6'd41: b = 17'd45802;
            6'd42: b = 17'd45794; 6'd43: b = 17'd45785; 6'd44: b = 17'd45778;
            6'd45: b = 17'd45770; 6'd46: b = 17'd45762; 6'd47: b = 17'd45755;
            6'd48: b = 17'd45749; 6'd49: b = 17'd45742; 6'd50: b = 17'd45736;
            6'd51: b = 17'd45730; 6'd52: b = 17'd45724; 6'd53: b = 17'd45719;
            6'd54: b = 17'd45713; 6'd55: b = 17'd45708; 6'd56: b = 17'd45703;
            6'd57: b = 17'd45698; 6'd58: b = 17'd45694; 6'd59: b = 17'd45689;
            6'd60: b = 17'd45685; 6'd61: b = 17'd45681; 6'd62: b = 17'd45677;
            default: b = 17'd45677;
        endcase
        return b;
    endfunction
endpackage

// ----- src/rms_div.sv -----
// Restoring radix-2 divider: floor((num << 16) / den), one quotient bit per cycle.
// Depends on rms_pkg.
`timescale 1ns / 1ps
module rms_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rms_pkg::t_div_req i_req,
    output rms_pkg::t_div_rsp o_rsp
);
    import rms_pkg::*;

    logic [QuoW-1:0]  r_quo, n_quo;
    logic [DataW:0]   r_rem, n_rem;
    logic [DataW-1:0] r_den, n_den;
    logic [5:0]       r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [DataW:0]   w_sh;

    // Shift one dividend bit in, subtract when it fits
    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_sh   = {r_rem[DataW-1:0], r_quo[QuoW-1]};
        if (i_req.start) begin
            n_quo  = {i_req.num, 16'd0};
            n_rem  = '0;
            n_den  = i_req.den;
            n_cnt  = 6'(QuoW - 1);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_sh >= {1'b0, r_den}) begin
                n_rem = w_sh - {1'b0, r_den};
                n_quo = {r_quo[QuoW-2:0], 1'b1};
            end else begin
                n_rem = w_sh;
                n_quo = {r_quo[QuoW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
        r_cnt <= n_cnt;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
endmodule

// ----- src/rms_task_mem.sv -----
// Task memory: period, compute and blocking words, one write and one read port.
// Depends on rms_pkg.
`timescale 1ns / 1ps
module rms_task_mem #(
    parameter int unsigned MAX_TASKS = rms_pkg::MaxTasksDefault
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [rms_pkg::IdxW-1:0] i_waddr,
    input  logic [3*rms_pkg::DataW-1:0] i_wdata,
    input  logic [rms_pkg::IdxW-1:0] i_raddr,
    output logic [3*rms_pkg::DataW-1:0] o_rdata
);
    import rms_pkg::*;

    logic [3*DataW-1:0] r_mem [MAX_TASKS];

    // Write the transfer, read registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- src/rms_order_mem.sv -----
// Order memory: sorted arrival indices, one write and one read port.
// Depends on rms_pkg.
`timescale 1ns / 1ps
module rms_order_mem #(
    parameter int unsigned MAX_TASKS = rms_pkg::MaxTasksDefault
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [rms_pkg::IdxW-1:0] i_waddr,
    input  logic [rms_pkg::IdxW-1:0] i_wdata,
    input  logic [rms_pkg::IdxW-1:0] i_raddr,
    output logic [rms_pkg::IdxW-1:0] o_rdata
);
    import rms_pkg::*;

    logic [IdxW-1:0] r_mem [MAX_TASKS];

    // Write the slot, read registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- src/rate_monotonic_schedulability_test_top.sv -----
// Channel  | Ports                                         | Handshake
// input    | i_period i_compute_time i_blocking_time       | start and !busy
//          | i_last_task                                   |
// result   | o_task_index o_schedulable o_last_result      | o_valid, one cycle
//
// Tasks load at one per cycle into the task memory. Unless more than MAX_TASKS
// arrive, the block then sorts by insertion (each compare-and-shift step passes the
// read, compare and write states after a fetch of each inserted period, so O(n^2)),
// tests the ranked tasks with two divisions each from the shared radix-2 divider,
// stops at the first failure and emits one result per task. busy stays high from the
// last task to the last result. Reset is synchronous and active low; results cannot be stalled.
// Depends on rms_pkg, rms_div, rms_task_mem, rms_order_mem and the assert header.
`timescale 1ns / 1ps
module rate_monotonic_schedulability_test_top #(
    parameter int unsigned MAX_TASKS = rms_pkg::MaxTasksDefault
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [rms_pkg::DataW-1:0] i_period,
    input  logic [rms_pkg::DataW-1:0] i_compute_time,
    input  logic [rms_pkg::DataW-1:0] i_blocking_time,
    input  logic                      i_last_task,
    output logic                      o_valid,
    output logic [rms_pkg::IdxW-1:0]  o_task_index,
    output logic                      o_schedulable,
    output logic                      o_last_result
);
    import rms_pkg::*;

`include "rate_monotonic_schedulability_test_top_assert.svh"

    t_state r_state, n_state;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic            r_ovf, n_ovf;
    logic [IdxW-1:0] r_i, n_i;
    logic [IdxW-1:0] r_j, n_j;
    logic [IdxW-1:0] r_cur, n_cur;
    logic [DataW-1:0] r_cur_per, n_cur_per;
    logic            r_phase, n_phase;
    logic            r_pass, n_pass;
    logic [SumW-1:0] r_sum, n_sum;
    logic            r_valid, n_valid;
    logic [IdxW-1:0] r_oidx, n_oidx;
    logic            r_olast, n_olast;

    logic                 w_accept;
    logic                 w_twe;
    logic [IdxW-1:0]      w_traddr;
    logic [3*DataW-1:0]   w_trd;
    logic                 w_owe;
    logic [IdxW-1:0]      w_owaddr, w_owdata, w_oraddr, w_ord;
    t_div_req             w_dreq;
    t_div_rsp             w_drsp;
    logic [DataW-1:0]     w_rd_per, w_rd_c, w_rd_b;
    logic [SumW-1:0]      w_tot;
    logic                 w_shift;

    assign w_accept = start && !busy;
    assign w_rd_per = w_trd[3*DataW-1 -: DataW];
    assign w_rd_c   = w_trd[2*DataW-1 -: DataW];
    assign w_rd_b   = w_trd[DataW-1:0];
    assign w_twe    = w_accept && (r_cnt < CntW'(MAX_TASKS));
    assign w_tot    = r_sum + SumW'(w_drsp.quo);
    // Shift the ranked entry up while the current period is strictly shorter
    assign w_shift  = (r_j != '0) && (r_cur_per < w_rd_per);

    rms_task_mem #(.MAX_TASKS(MAX_TASKS)) u_task (
        .i_clk  (i_clk),
        .i_we   (w_twe),
        .i_waddr(r_cnt[IdxW-1:0]),
        .i_wdata({i_period, i_compute_time, i_blocking_time}),
        .i_raddr(w_traddr),
        .o_rdata(w_trd)
    );

    rms_order_mem #(.MAX_TASKS(MAX_TASKS)) u_order (
        .i_clk  (i_clk),
        .i_we   (w_owe),
        .i_waddr(w_owaddr),
        .i_wdata(w_owdata),
        .i_raddr(w_oraddr),
        .o_rdata(w_ord)
    );

    rms_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_dreq),
        .o_rsp  (w_drsp)
    );

    // Next state and datapath updates
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_ovf     = r_ovf;
        n_i       = r_i;
        n_j       = r_j;
        n_cur     = r_cur;
        n_cur_per = r_cur_per;
        n_phase   = r_phase;
        n_pass    = r_pass;
        n_sum     = r_sum;
        n_valid   = 1'b0;
        n_oidx    = r_oidx;
        n_olast   = 1'b0;
        case (r_state)
            ST_LOAD: begin
                if (w_accept) begin
                    if (w_twe) begin
                        n_cnt = r_cnt + CntW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_last_task) begin
                        if (r_ovf || !w_twe) begin
                            n_valid = 1'b1;
                            n_oidx  = '0;
                            n_olast = 1'b1;
                            n_pass  = 1'b0;
                            n_cnt   = '0;
                            n_ovf   = 1'b0;
                        end else begin
                            n_state = ST_INIT;
                            n_i     = '0;
                        end
                    end
                end
            end
            // Seed order slot 0, then insert task i at slot i
            ST_INIT: begin
                n_i = IdxW'(1);
                if (r_cnt == CntW'(1)) begin
                    n_state = ST_TST_RD;
                    n_i     = '0;
                    n_sum   = '0;
                    n_pass  = 1'b1;
                    n_phase = 1'b0;
                end else begin
                    n_state = ST_SORT_RD;
                    n_cur   = IdxW'(1);
                    n_j     = IdxW'(1);
                    n_phase = 1'b0;
                end
            end
            ST_SORT_RD: begin
                n_state = ST_SORT_CMP;
            end
            ST_SORT_CMP: begin
                if (!r_phase) begin
                    // current period read
                    n_cur_per = w_rd_per;
                    n_phase   = 1'b1;
                    n_state   = ST_SORT_RD;
                end else begin
                    n_state = ST_SORT_WR;
                end
            end
            ST_SORT_WR: begin
                if (w_shift) begin
                    n_j     = r_j - IdxW'(1);
                    n_state = (r_j == IdxW'(1)) ? ST_SORT_WR : ST_SORT_RD;
                end else begin
                    // place current and move to next insertion
                    if (CntW'(r_i) + CntW'(1) == r_cnt) begin
                        n_state = ST_TST_RD;
                        n_i     = '0;
                        n_sum   = '0;
                        n_pass  = 1'b1;
                    end else begin
                        n_i     = r_i + IdxW'(1);
                        n_cur   = r_i + IdxW'(1);
                        n_j     = r_i + IdxW'(1);
                        n_state = ST_SORT_RD;
                    end
                    n_phase = 1'b0;
                end
            end
            ST_TST_RD: begin
                n_state = ST_TST_LD;
                n_phase = 1'b0;
            end
            ST_TST_LD: begin
                n_state = ST_TST_DIV;
            end
            ST_TST_DIV: begin
                n_state = ST_TST_CHK;
            end
            ST_TST_CHK: begin
                if (w_drsp.done) begin
                    if (!r_phase) begin
                        n_sum   = r_sum + SumW'(w_drsp.quo);
                        n_phase = 1'b1;
                    end else begin
                        if (w_tot >= SumW'(bound_q16(r_i))) begin
                            n_pass = 1'b0;
                        end
                        if (CntW'(r_i) + CntW'(1) == r_cnt ||
                                w_tot >= SumW'(bound_q16(r_i))) begin
                            n_state = ST_OUT_RD;
                            n_i     = '0;
                        end else begin
                            n_i     = r_i + IdxW'(1);
                            n_state = ST_TST_RD;
                        end
                    end
                end
            end
            ST_OUT_RD: begin
                n_state = ST_OUT_EMIT;
            end
            ST_OUT_EMIT: begin
                n_valid = 1'b1;
                n_oidx  = w_ord;
                if (CntW'(r_i) + CntW'(1) == r_cnt) begin
                    n_olast = 1'b1;
                    n_state = ST_LOAD;
                    n_cnt   = '0;
                    n_ovf   = 1'b0;
                end else begin
                    n_i     = r_i + IdxW'(1);
                    n_state = ST_OUT_RD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // Memory addresses, writes and divider requests
    always_comb begin
        w_traddr = '0;
        w_oraddr = '0;
        w_owe    = 1'b0;
        w_owaddr = '0;
        w_owdata = '0;
        w_dreq   = '0;
        case (r_state)
            ST_INIT: begin
                w_owe = 1'b1;
            end
            ST_SORT_RD: begin
                if (!r_phase) begin
                    w_traddr = r_cur;
                end else begin
                    w_oraddr = r_j - IdxW'(1);
                end
            end
            ST_SORT_CMP: begin
                w_traddr = w_ord;
                w_oraddr = r_j - IdxW'(1);
            end
            ST_SORT_WR: begin
                w_owe    = 1'b1;
                w_owaddr = r_j;
                w_owdata = w_shift ? w_ord : r_cur;
            end
            ST_TST_RD: begin
                w_oraddr = r_i;
            end
            ST_TST_LD: begin
                w_traddr = w_ord;
                w_oraddr = r_i;
            end
            ST_TST_DIV: begin
                w_traddr = w_ord;
                w_oraddr = r_i;
            end
            ST_TST_CHK: begin
                w_traddr = w_ord;
                w_oraddr = r_i;
            end
            ST_OUT_RD: begin
                w_oraddr = r_i;
            end
            default: ;
        endcase
        if (r_state == ST_TST_CHK && !r_phase && w_drsp.done) begin
            w_dreq.start = 1'b1;
            w_dreq.num   = w_rd_b;
            w_dreq.den   = w_rd_per;
        end
        if (r_state == ST_TST_DIV) begin
            w_dreq.start = 1'b1;
            w_dreq.num   = w_rd_c;
            w_dreq.den   = w_rd_per;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_valid <= 1'b0;
            r_olast <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ovf   <= n_ovf;
            r_valid <= n_valid;
            r_olast <= n_olast;
        end
        r_i       <= n_i;
        r_j       <= n_j;
        r_cur     <= n_cur;
        r_cur_per <= n_cur_per;
        r_phase   <= n_phase;
        r_pass    <= n_pass;
        r_sum     <= n_sum;
        r_oidx    <= n_oidx;
    end

    // Outputs
    always_comb begin
        busy          = (r_state != ST_LOAD);
        o_valid       = r_valid;
        o_task_index  = r_oidx;
        o_schedulable = r_valid && r_pass;
        o_last_result = r_olast;
    end

    `RMS_ASSERT_IMPL(a_last_needs_valid, o_last_result, o_valid, "last without valid")
    `RMS_ASSERT_IMPL(a_cnt_range, 1'b1, r_cnt <= CntW'(MAX_TASKS), "task count over limit")
    `RMS_ASSERT_IMPL(a_last_idle, o_valid && o_last_result, !busy, "busy at last result")
endmodule
